// ===== design/ssidx_pkg.sv =====
// Shared constants and types for the scan-result network name extractor.
package ssidx_pkg;

  localparam int LEN_W         = 13;
  localparam int CNT_W         = 6;
  localparam int SLOT_W        = 5;
  localparam int CHAR_W        = 7;
  localparam int NAME_MAX      = 32;
  localparam int HDR_BYTES     = 12;
  localparam int REC_HDR_BYTES = 51;

  localparam int DEF_BUFFER_BYTES = 4096;
  localparam int DEF_MAX_RECORDS  = 32;

  localparam logic [7:0]       REC_VERSION     = 8'd109;
  localparam logic [7:0]       CHAR_LO         = 8'd32;
  localparam logic [7:0]       CHAR_HI         = 8'd126;
  localparam logic [CNT_W-1:0] MAX_NAMES_RESET = 6'd32;

  localparam logic [LEN_W-1:0] POS_COUNT_LO  = 13'd10;
  localparam logic [LEN_W-1:0] POS_COUNT_HI  = 13'd11;
  localparam logic [LEN_W-1:0] REL_VER0      = 13'd0;
  localparam logic [LEN_W-1:0] REL_VER3      = 13'd3;
  localparam logic [LEN_W-1:0] REL_LEN0      = 13'd4;
  localparam logic [LEN_W-1:0] REL_LEN1      = 13'd5;
  localparam logic [LEN_W-1:0] REL_LEN3      = 13'd7;
  localparam logic [LEN_W-1:0] REL_NAME_LEN  = 13'd18;
  localparam logic [LEN_W-1:0] REL_NAME0     = 13'd19;
  localparam logic [LEN_W-1:0] REL_LAST      = 13'd50;

  localparam logic RK_NAME    = 1'b0;
  localparam logic RK_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_RECORD,
    PH_DONE
  } phase_t;

  function automatic logic is_printable(input logic [7:0] b);
    return (b >= CHAR_LO) && (b <= CHAR_HI);
  endfunction

endpackage

// ===== design/scan_result_ssid_extractor.sv =====
// Scan-result buffer parser that emits network name bytes and a per-buffer summary.
//
// The block takes one buffer byte per cycle. A byte that completes a record header
// whose name is emitted holds the input until every byte of the name (1 to 32) has
// left the 32-entry name store, one byte per cycle while the output is not stalled,
// through the output register. The final byte of a buffer holds the input until its
// summary is handed to the output register. All other bytes are taken back to back,
// also while a finished result waits in the output register.
module scan_result_ssid_extractor
  import ssidx_pkg::*;
#(
  parameter int BUFFER_BYTES = DEF_BUFFER_BYTES,
  parameter int MAX_RECORDS  = DEF_MAX_RECORDS
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr_en,
  input  logic [CNT_W-1:0]  cfg_wr_data,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [7:0]        in_data_byte,
  input  logic [LEN_W-1:0]  in_buffer_length,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_result_kind,
  output logic [SLOT_W-1:0] out_name_slot,
  output logic [CHAR_W-1:0] out_name_byte,
  output logic              out_name_end,
  output logic [CNT_W-1:0]  out_names_found,
  output logic [CNT_W-1:0]  out_records_seen,
  output logic [CNT_W-1:0]  out_records_skipped
);

  logic [CNT_W-1:0]  max_names_r;
  logic [LEN_W-1:0]  pos_r, pos_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  phase_t            phase_r, phase_nxt;
  logic [CNT_W-1:0]  left_r, left_nxt;
  logic [LEN_W-1:0]  start_r, start_nxt;
  logic [LEN_W-1:0]  rlen_r, rlen_nxt;
  logic              rlen_big_r, rlen_big_nxt;
  logic [31:0]       ver_r, ver_nxt;
  logic [7:0]        nlen_r, nlen_nxt;
  logic              name_ok_r, name_ok_nxt;
  logic [CNT_W-1:0]  found_r, found_nxt;
  logic [CNT_W-1:0]  seen_r, seen_nxt;
  logic [CNT_W-1:0]  skip_r, skip_nxt;

  logic [CHAR_W-1:0] name_store [NAME_MAX];
  logic              st_wr;
  logic [SLOT_W-1:0] st_addr;

  logic              emit_act_r, emit_act_nxt;
  logic [SLOT_W-1:0] emit_idx_r, emit_idx_nxt;
  logic [CNT_W-1:0]  emit_len_r, emit_len_nxt;
  logic [SLOT_W-1:0] emit_slot_r, emit_slot_nxt;
  logic              sum_pend_r, sum_pend_nxt;
  logic [CNT_W-1:0]  sum_found_r, sum_found_nxt;
  logic [CNT_W-1:0]  sum_seen_r, sum_seen_nxt;
  logic [CNT_W-1:0]  sum_skip_r, sum_skip_nxt;

  logic              out_valid_r, out_valid_nxt;
  logic              out_kind_r, out_kind_nxt;
  logic [SLOT_W-1:0] out_slot_r, out_slot_nxt;
  logic [CHAR_W-1:0] out_byte_r, out_byte_nxt;
  logic              out_end_r, out_end_nxt;
  logic [CNT_W-1:0]  out_found_r, out_found_nxt;
  logic [CNT_W-1:0]  out_seen_r, out_seen_nxt;
  logic [CNT_W-1:0]  out_skip_r, out_skip_nxt;

  logic              in_acc;
  logic              first;
  logic [LEN_W-1:0]  len_sat;
  logic [LEN_W-1:0]  rel;
  logic [LEN_W-1:0]  name_idx;
  logic [15:0]       cnt16;
  logic [CNT_W-1:0]  lim;
  logic              valid_rec;
  logic [LEN_W:0]    next14;
  logic [LEN_W+1:0]  next_hdr;
  logic              emit_start;
  logic              last;
  logic              out_free;
  logic              emit_last;

  assign in_stall = emit_act_r | sum_pend_r;
  assign in_acc   = in_valid & ~in_stall;
  assign first    = (pos_r == '0);

  always_comb begin
    len_sat = in_buffer_length;
    if (32'(in_buffer_length) > 32'(BUFFER_BYTES)) begin
      len_sat = LEN_W'(BUFFER_BYTES);
    end
    len_nxt      = first ? len_sat : len_r;
    phase_nxt    = phase_r;
    found_nxt    = found_r;
    seen_nxt     = seen_r;
    skip_nxt     = skip_r;
    if (first) begin
      phase_nxt = ((32'(len_sat) < (HDR_BYTES + REC_HDR_BYTES)) || (max_names_r == '0)) ?
                  PH_DONE : PH_HEADER;
      found_nxt = '0;
      seen_nxt  = '0;
      skip_nxt  = '0;
    end
    left_nxt     = left_r;
    start_nxt    = start_r;
    rlen_nxt     = rlen_r;
    rlen_big_nxt = rlen_big_r;
    ver_nxt      = ver_r;
    nlen_nxt     = nlen_r;
    name_ok_nxt  = name_ok_r;
    st_wr        = 1'b0;
    rel          = pos_r - start_r;
    name_idx     = rel - REL_NAME0;
    st_addr      = name_idx[SLOT_W-1:0];
    cnt16        = {in_data_byte, ver_r[7:0]};
    lim          = (max_names_r > CNT_W'(NAME_MAX)) ? CNT_W'(NAME_MAX) : max_names_r;
    valid_rec    = 1'b0;
    next14       = {1'b0, start_r} + {1'b0, rlen_r};
    next_hdr     = {1'b0, next14} + (LEN_W+2)'(REC_HDR_BYTES);
    emit_start   = 1'b0;

    if (phase_nxt == PH_HEADER) begin
      if (pos_r == POS_COUNT_LO) begin
        ver_nxt = {24'd0, in_data_byte};
      end else if (pos_r == POS_COUNT_HI) begin
        if (cnt16 == '0) begin
          left_nxt = CNT_W'(1);
        end else if (32'(cnt16) > 32'(MAX_RECORDS)) begin
          left_nxt = CNT_W'(MAX_RECORDS);
        end else begin
          left_nxt = cnt16[CNT_W-1:0];
        end
        start_nxt = LEN_W'(HDR_BYTES);
        phase_nxt = (32'(len_nxt) < (HDR_BYTES + REC_HDR_BYTES)) ? PH_DONE : PH_RECORD;
      end
    end else if (phase_nxt == PH_RECORD && pos_r >= start_r) begin
      if (rel == REL_VER0) begin
        ver_nxt = {24'd0, in_data_byte};
      end else if (rel <= REL_VER3) begin
        ver_nxt[8*rel[1:0] +: 8] = in_data_byte;
      end else if (rel == REL_LEN0) begin
        rlen_nxt     = {5'd0, in_data_byte};
        rlen_big_nxt = 1'b0;
      end else if (rel == REL_LEN1) begin
        rlen_nxt[LEN_W-1:8] = in_data_byte[LEN_W-9:0];
        rlen_big_nxt        = |in_data_byte[7:LEN_W-8];
      end else if (rel <= REL_LEN3) begin
        rlen_big_nxt = rlen_big_r | (|in_data_byte);
      end else if (rel == REL_NAME_LEN) begin
        nlen_nxt    = in_data_byte;
        name_ok_nxt = (in_data_byte >= 8'd1) && (32'(in_data_byte) <= NAME_MAX);
      end else if (rel >= REL_NAME0 && rel <= REL_LAST) begin
        st_wr = 1'b1;
        if ((name_idx < {5'd0, nlen_r}) && !is_printable(in_data_byte)) begin
          name_ok_nxt = 1'b0;
        end
      end
      if (rel == REL_LAST) begin
        valid_rec = name_ok_nxt &&
                    ((ver_r == {24'd0, REC_VERSION}) || (ver_r == {REC_VERSION, 24'd0}));
        seen_nxt = seen_r + 1'b1;
        if (!valid_rec) begin
          skip_nxt = skip_r + 1'b1;
        end else if (found_r < lim) begin
          emit_start = 1'b1;
          found_nxt  = found_r + 1'b1;
        end
        left_nxt = (left_r != '0) ? left_r - 1'b1 : left_r;
        if (rlen_big_r || (32'(rlen_r) < REC_HDR_BYTES) || (next14 > {1'b0, len_nxt}) ||
            (left_nxt == '0) || (next_hdr > {2'b0, len_nxt})) begin
          phase_nxt = PH_DONE;
        end else begin
          start_nxt = next14[LEN_W-1:0];
        end
      end
    end

    last    = ({1'b0, pos_r} + 1'b1) >= {1'b0, len_nxt};
    pos_nxt = last ? '0 : pos_r + 1'b1;
  end

  always_comb begin
    out_free      = ~out_valid_r | ~out_stall;
    emit_last     = ({1'b0, emit_idx_r} + 1'b1) == emit_len_r;
    emit_act_nxt  = emit_act_r;
    emit_idx_nxt  = emit_idx_r;
    emit_len_nxt  = emit_len_r;
    emit_slot_nxt = emit_slot_r;
    sum_pend_nxt  = sum_pend_r;
    sum_found_nxt = sum_found_r;
    sum_seen_nxt  = sum_seen_r;
    sum_skip_nxt  = sum_skip_r;
    out_valid_nxt = out_valid_r;
    out_kind_nxt  = out_kind_r;
    out_slot_nxt  = out_slot_r;
    out_byte_nxt  = out_byte_r;
    out_end_nxt   = out_end_r;
    out_found_nxt = out_found_r;
    out_seen_nxt  = out_seen_r;
    out_skip_nxt  = out_skip_r;

    if (out_free) begin
      out_valid_nxt = 1'b0;
      if (emit_act_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = RK_NAME;
        out_slot_nxt  = emit_slot_r;
        out_end_nxt   = emit_last;
        out_found_nxt = '0;
        out_seen_nxt  = '0;
        out_skip_nxt  = '0;
        emit_idx_nxt  = emit_idx_r + 1'b1;
        if (emit_last) begin
          emit_act_nxt = 1'b0;
        end
      end else if (sum_pend_r) begin
        out_valid_nxt = 1'b1;
        out_kind_nxt  = RK_SUMMARY;
        out_slot_nxt  = '0;
        out_byte_nxt  = '0;
        out_end_nxt   = 1'b0;
        out_found_nxt = sum_found_r;
        out_seen_nxt  = sum_seen_r;
        out_skip_nxt  = sum_skip_r;
        sum_pend_nxt  = 1'b0;
      end
    end

    if (in_acc) begin
      if (emit_start) begin
        emit_act_nxt  = 1'b1;
        emit_idx_nxt  = '0;
        emit_len_nxt  = nlen_nxt[CNT_W-1:0];
        emit_slot_nxt = found_r[SLOT_W-1:0];
      end
      if (last) begin
        sum_pend_nxt  = 1'b1;
        sum_found_nxt = found_nxt;
        sum_seen_nxt  = seen_nxt;
        sum_skip_nxt  = skip_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_wr && in_acc) begin
      name_store[st_addr] <= in_data_byte[CHAR_W-1:0];
    end
    if (out_free && emit_act_r) begin
      out_byte_r <= name_store[emit_idx_r];
    end else begin
      out_byte_r <= out_byte_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_names_r <= MAX_NAMES_RESET;
      pos_r       <= '0;
      len_r       <= '0;
      phase_r     <= PH_HEADER;
      found_r     <= '0;
      seen_r      <= '0;
      skip_r      <= '0;
      emit_act_r  <= 1'b0;
      sum_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        max_names_r <= cfg_wr_data;
      end
      if (in_acc) begin
        pos_r   <= pos_nxt;
        len_r   <= len_nxt;
        phase_r <= phase_nxt;
        found_r <= found_nxt;
        seen_r  <= seen_nxt;
        skip_r  <= skip_nxt;
      end
      emit_act_r  <= emit_act_nxt;
      sum_pend_r  <= sum_pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      left_r     <= left_nxt;
      start_r    <= start_nxt;
      rlen_r     <= rlen_nxt;
      rlen_big_r <= rlen_big_nxt;
      ver_r      <= ver_nxt;
      nlen_r     <= nlen_nxt;
      name_ok_r  <= name_ok_nxt;
    end
    emit_idx_r  <= emit_idx_nxt;
    emit_len_r  <= emit_len_nxt;
    emit_slot_r <= emit_slot_nxt;
    sum_found_r <= sum_found_nxt;
    sum_seen_r  <= sum_seen_nxt;
    sum_skip_r  <= sum_skip_nxt;
    out_kind_r  <= out_kind_nxt;
    out_slot_r  <= out_slot_nxt;
    out_end_r   <= out_end_nxt;
    out_found_r <= out_found_nxt;
    out_seen_r  <= out_seen_nxt;
    out_skip_r  <= out_skip_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_name_slot       = out_slot_r;
  assign out_name_byte       = out_byte_r;
  assign out_name_end        = out_end_r;
  assign out_names_found     = out_found_r;
  assign out_records_seen    = out_seen_r;
  assign out_records_skipped = out_skip_r;

  // A name transaction always carries a printable byte.
  a_name_printable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RK_NAME) |->
      (out_name_byte >= CHAR_LO[CHAR_W-1:0]) && (out_name_byte <= CHAR_HI[CHAR_W-1:0]))
    else $error("name byte outside the printable range");

  // Summary counts stay consistent with each other.
  a_summary_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_result_kind == RK_SUMMARY) |->
      (out_names_found <= CNT_W'(NAME_MAX)) && (out_records_skipped <= out_records_seen) &&
      (out_names_found <= out_records_seen))
    else $error("inconsistent summary counts");

  // The name emitter never runs past the length it was started with.
  a_emit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    emit_act_r |-> (({1'b0, emit_idx_r} < emit_len_r) && (emit_len_r <= CNT_W'(NAME_MAX))))
    else $error("name emitter index out of range");

  // A name's last byte ends the emission unless a stall holds it.
  a_emit_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_act_r && out_free && emit_last) |=> !emit_act_r)
    else $error("name emitter did not stop after the last byte");

endmodule

// ===== verif/scan_result_ssid_extractor_tb.sv =====
// Self-checking testbench for the scan-result network name extractor.
module scan_result_ssid_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ssidx_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 20;
  localparam int CFG_PAUSE = 8;
  localparam int MAX_REPORTS = 10;
  localparam logic [31:0] VER_SWAPPED = {REC_VERSION, 24'd0};

  typedef struct packed {
    logic              kind;
    logic [SLOT_W-1:0] slot;
    logic [CHAR_W-1:0] chr;
    logic              name_end;
    logic [CNT_W-1:0]  found;
    logic [CNT_W-1:0]  seen;
    logic [CNT_W-1:0]  skipped;
  } scan_out_t;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_BURSTY
  } stall_mode_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_wr_en;
  logic [CNT_W-1:0]  cfg_wr_data;
  logic              in_valid;
  logic              in_stall;
  logic [7:0]        in_data_byte;
  logic [LEN_W-1:0]  in_buffer_length;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              out_result_kind;
  logic [SLOT_W-1:0] out_name_slot;
  logic [CHAR_W-1:0] out_name_byte;
  logic              out_name_end;
  logic [CNT_W-1:0]  out_names_found;
  logic [CNT_W-1:0]  out_records_seen;
  logic [CNT_W-1:0]  out_records_skipped;

  logic [CNT_W-1:0] max_names_m;
  logic [LEN_W-1:0] pos_m;
  logic [LEN_W-1:0] len_m;
  logic [LEN_W-1:0] rec_start_m;
  phase_t           phase_m;
  logic [5:0]       recs_left_m;
  logic [31:0]      rec_len_m;
  logic [31:0]      word_m;
  logic [7:0]       name_len_m;
  logic [7:0]       name_m [NAME_MAX];
  logic [CNT_W-1:0] found_m;
  logic [CNT_W-1:0] seen_m;
  logic [CNT_W-1:0] skipped_m;

  scan_out_t   ssid_q[$];
  logic [7:0]  scan_buf[$];
  int          mismatch_count = 0;
  int          burst_left = 16;
  bit          gaps_on = 1'b1;
  stall_mode_t stall_mode = STALL_NONE;
  int          stall_run = 0;
  int          idle_cycles;

  scan_result_ssid_extractor uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_wr_data         (cfg_wr_data),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_data_byte        (in_data_byte),
    .in_buffer_length    (in_buffer_length),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_result_kind     (out_result_kind),
    .out_name_slot       (out_name_slot),
    .out_name_byte       (out_name_byte),
    .out_name_end        (out_name_end),
    .out_names_found     (out_names_found),
    .out_records_seen    (out_records_seen),
    .out_records_skipped (out_records_skipped)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  task automatic clear_parse();
    pos_m = '0;
    phase_m = PH_HEADER;
    recs_left_m = '0;
    rec_start_m = '0;
    rec_len_m = '0;
    word_m = '0;
    name_len_m = '0;
    found_m = '0;
    seen_m = '0;
    skipped_m = '0;
  endtask

  task automatic reset_model();
    int i;
    clear_parse();
    len_m = '0;
    for (i = 0; i < NAME_MAX; i++) name_m[i] = '0;
    max_names_m = MAX_NAMES_RESET;
  endtask

  task automatic judge_record();
    logic ok;
    int i;
    int lim;
    longint unsigned next_start;
    lim = (max_names_m > NAME_MAX) ? NAME_MAX : int'(max_names_m);
    ok = (word_m == REC_VERSION || word_m == VER_SWAPPED) && name_len_m >= 1 &&
         name_len_m <= NAME_MAX;
    for (i = 0; i < NAME_MAX; i++) begin
      if (ok && i < name_len_m && (name_m[i] < CHAR_LO || name_m[i] > CHAR_HI)) ok = 1'b0;
    end
    seen_m = seen_m + 1'b1;
    if (!ok) begin
      skipped_m = skipped_m + 1'b1;
    end else if (found_m < lim) begin
      for (i = 0; i < name_len_m; i++) begin
        ssid_q.push_back('{RK_NAME, found_m[SLOT_W-1:0], name_m[i][CHAR_W-1:0],
                           (i + 1 == name_len_m), '0, '0, '0});
      end
      found_m = found_m + 1'b1;
    end
    if (recs_left_m > 0) recs_left_m = recs_left_m - 1'b1;
    next_start = 64'(rec_start_m) + 64'(rec_len_m);
    if (rec_len_m < REC_HDR_BYTES || next_start > len_m || recs_left_m == 0 ||
        next_start + REC_HDR_BYTES > len_m) begin
      phase_m = PH_DONE;
    end else begin
      rec_start_m = next_start[LEN_W-1:0];
    end
  endtask

  task automatic extract_ssid_byte(input logic [7:0] b, input logic [LEN_W-1:0] len_in);
    logic [LEN_W-1:0] rel;
    logic [15:0] cnt;
    if (pos_m == 0) begin
      clear_parse();
      len_m = (len_in > DEF_BUFFER_BYTES) ? LEN_W'(DEF_BUFFER_BYTES) : len_in;
      if (len_m < HDR_BYTES + REC_HDR_BYTES || max_names_m == 0) phase_m = PH_DONE;
    end
    if (phase_m == PH_HEADER) begin
      if (pos_m == POS_COUNT_LO) begin
        word_m = {24'd0, b};
      end else if (pos_m == POS_COUNT_HI) begin
        cnt = {b, word_m[7:0]};
        if (cnt < 1) cnt = 16'd1;
        if (cnt > DEF_MAX_RECORDS) cnt = 16'(DEF_MAX_RECORDS);
        recs_left_m = cnt[5:0];
        rec_start_m = LEN_W'(HDR_BYTES);
        phase_m = (HDR_BYTES + REC_HDR_BYTES > len_m) ? PH_DONE : PH_RECORD;
      end
    end else if (phase_m == PH_RECORD && pos_m >= rec_start_m) begin
      rel = pos_m - rec_start_m;
      if (rel == REL_VER0) word_m = {24'd0, b};
      else if (rel <= REL_VER3) word_m[8*rel +: 8] = b;
      else if (rel == REL_LEN0) rec_len_m = {24'd0, b};
      else if (rel <= REL_LEN3) rec_len_m[8*(rel - REL_LEN0) +: 8] = b;
      else if (rel == REL_NAME_LEN) name_len_m = b;
      else if (rel >= REL_NAME0 && rel <= REL_LAST) name_m[rel - REL_NAME0] = b;
      if (rel == REL_LAST) judge_record();
    end
    if (pos_m + 1 >= len_m) begin
      ssid_q.push_back('{RK_SUMMARY, '0, '0, 1'b0, found_m, seen_m, skipped_m});
      clear_parse();
    end else begin
      pos_m = pos_m + 1'b1;
    end
  endtask

  function automatic string show(scan_out_t r);
    return $sformatf("kind=%0d slot=%0d byte=%0d end=%0d found=%0d seen=%0d skipped=%0d",
                     r.kind, r.slot, r.chr, r.name_end, r.found, r.seen, r.skipped);
  endfunction

  always @(posedge clk) begin
    scan_out_t got;
    scan_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_result_kind, out_name_slot, out_name_byte, out_name_end,
              out_names_found, out_records_seen, out_records_skipped};
      if (ssid_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) $display("Unexpected transaction: %s", show(got));
      end else begin
        want = ssid_q.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("Mismatch: expected %s", show(want));
            $display("          actual   %s", show(got));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_run <= $urandom_range(32, 300);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      STALL_NONE: out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 1) == 0);
      default: out_stall <= (stall_run[3:0] < 4'd11);
    endcase
  end

  initial begin
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  task automatic send_byte(input logic [7:0] b, input logic [LEN_W-1:0] len_field);
    in_valid <= 1'b1;
    in_data_byte <= b;
    in_buffer_length <= len_field;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    extract_ssid_byte(b, len_field);
    burst_left--;
    if (gaps_on && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = $urandom_range(1, 48);
    end
  endtask

  // The length field only matters on the first byte, so later bytes carry noise there.
  task automatic send_buffer(input logic [LEN_W-1:0] len_field);
    int n;
    int i;
    n = (len_field == 0) ? 1 : ((len_field > DEF_BUFFER_BYTES) ? DEF_BUFFER_BYTES :
                                 int'(len_field));
    gaps_on = ($urandom_range(0, 3) != 0);
    for (i = 0; i < n; i++) begin
      send_byte((i < scan_buf.size()) ? scan_buf[i] : 8'($urandom),
                (i == 0) ? len_field : LEN_W'($urandom));
    end
  endtask

  task automatic wait_drained();
    while (ssid_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_max_names(input logic [CNT_W-1:0] value);
    in_valid <= 1'b0;
    wait_drained();
    repeat (CFG_PAUSE) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    max_names_m = value;
    cfg_wr_en <= 1'b0;
  endtask

  task automatic open_buffer(input int count);
    int i;
    scan_buf = {};
    for (i = 0; i < HDR_BYTES - 2; i++) scan_buf.push_back(8'($urandom));
    scan_buf.push_back(count[7:0]);
    scan_buf.push_back(count[15:8]);
  endtask

  task automatic add_record(input logic [31:0] ver, input logic [31:0] rec_len,
                            input logic [7:0] nlen, input int bad_pos,
                            input logic [7:0] bad_char, input int pad);
    int i;
    for (i = 0; i < 4; i++) scan_buf.push_back(ver[8*i +: 8]);
    for (i = 0; i < 4; i++) scan_buf.push_back(rec_len[8*i +: 8]);
    for (i = 8; i < REL_NAME_LEN; i++) scan_buf.push_back(8'($urandom));
    scan_buf.push_back(nlen);
    for (i = 0; i < NAME_MAX; i++) begin
      if (i == bad_pos) scan_buf.push_back(bad_char);
      else if (i < nlen) scan_buf.push_back(8'($urandom_range(CHAR_LO, CHAR_HI)));
      else scan_buf.push_back(8'($urandom));
    end
    for (i = 0; i < pad; i++) scan_buf.push_back(8'($urandom));
  endtask

  task automatic test_short_buffers();
    scan_buf = {};
    send_buffer('0);
    send_buffer(LEN_W'(1));
    send_buffer(LEN_W'(2));
  endtask

  task automatic test_record_checks();
    int i;
    int base;
    write_max_names(6'd63);
    open_buffer(2);
    add_record(VER_SWAPPED, REC_HDR_BYTES, 8'd32, -1, '0, 0);
    base = scan_buf.size() - NAME_MAX;
    for (i = 0; i < NAME_MAX; i++) scan_buf[base + i] = i[0] ? CHAR_HI : CHAR_LO;
    add_record(REC_VERSION, REC_HDR_BYTES, 8'd8, 7, 8'd127, 0);
    send_buffer(LEN_W'(scan_buf.size()));
  endtask

  task automatic test_random_buffers();
    int n;
    for (n = 0; n < 4; n++) begin
      case ($urandom_range(0, 2))
        0: write_max_names('0);
        1: write_max_names(6'($urandom_range(33, 63)));
        default: write_max_names(6'($urandom_range(1, 32)));
      endcase
      scan_buf = {};
      send_buffer(LEN_W'($urandom_range(0, 5)));
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_valid = 1'b0;
    in_data_byte = '0;
    in_buffer_length = '0;
    reset_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_short_buffers();
    test_record_checks();
    test_random_buffers();
    in_valid <= 1'b0;
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/ssidx_pkg.sv
design/scan_result_ssid_extractor.sv
verif/scan_result_ssid_extractor_tb.sv
